[src/rle_pkg.sv]
// Shared types, codes and helpers for the ring leader election node.
`default_nettype none

package rle_pkg;

	// Ring size; the highest-id node starts an election on the start event
	localparam logic [15:0] RING_NODES = 16'd6;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Input item modes
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_MSG   = 2'd1,
		MODE_START = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Message kinds
	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_ELECTION = 2'd1,
		KIND_COORD    = 2'd2,
		KIND_ALIVE    = 2'd3
	} kind_t;

	// Node roles
	typedef enum logic [1:0] {
		ROLE_NORMAL     = 2'd0,
		ROLE_ELECTION   = 2'd1,
		ROLE_WAIT_COORD = 2'd2
	} role_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_NODE_ID       = 2'd0,
		REG_ELECTION_TO   = 2'd1,
		REG_COORDINATOR_TO = 2'd2,
		REG_ALIVE_INTERVAL = 2'd3
	} reg_idx_t;

	// One outgoing message
	typedef struct packed {
		kind_t       kind;
		logic [15:0] initiator;
		logic [15:0] candidate;
		logic [15:0] seqnum;
	} msg_t;

	// Everything one accepted item produces
	typedef struct packed {
		logic [1:0]  nres;      // results to deliver, 1..2
		logic        has_msg;   // results carry messages
		msg_t [2:0]  msgs;
		logic [15:0] target;
		logic [15:0] leader;
		role_t       role;
		logic        electing;
	} bundle_t;

	// Front to queue
	typedef struct packed {
		logic    push;
		bundle_t data;
	} qpush_t;

	// Queue head to back
	typedef struct packed {
		logic    valid;
		bundle_t data;
	} qhead_t;

	// Timer reload: a zero register acts as one
	function automatic logic [23:0] load_val(input logic [23:0] r);
		return (r == 24'd0) ? 24'd1 : r;
	endfunction

endpackage

`default_nettype wire

[src/rle_ifs.sv]
// Item and result channel interfaces of the ring leader election node.
`default_nettype none

interface rle_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic        frame_size_ok;
	logic [7:0]  msg_kind;
	logic [15:0] msg_initiator;
	logic [15:0] msg_candidate;
	logic [15:0] msg_sequence;
	logic [15:0] msg_target;

	modport source (
		output valid, mode, frame_size_ok, msg_kind, msg_initiator, msg_candidate,
			msg_sequence, msg_target,
		input  ready
	);
	modport sink (
		input  valid, mode, frame_size_ok, msg_kind, msg_initiator, msg_candidate,
			msg_sequence, msg_target,
		output ready
	);
endinterface

interface rle_out_if;
	logic        valid;
	logic        ready;
	logic        send_valid;
	logic [1:0]  out_kind;
	logic [15:0] out_initiator;
	logic [15:0] out_candidate;
	logic [15:0] out_sequence;
	logic [15:0] out_target;
	logic [15:0] leader_now;
	logic [1:0]  role_now;
	logic        electing_now;
	logic        last_result;

	modport source (
		output valid, send_valid, out_kind, out_initiator, out_candidate, out_sequence,
			out_target, leader_now, role_now, electing_now, last_result,
		input  ready
	);
	modport sink (
		input  valid, send_valid, out_kind, out_initiator, out_candidate, out_sequence,
			out_target, leader_now, role_now, electing_now, last_result,
		output ready
	);
endinterface

`default_nettype wire

[src/rle_front.sv]
// Front: configuration registers, node state and per-item classification.
`default_nettype none

module rle_front import rle_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [23:0] wr_data,
	rle_in_if.sink           item,
	input  wire logic        q_full,
	output qpush_t           qpush
);

	logic [15:0] node_id_q;
	logic [23:0] elec_to_q, coord_to_q, alive_to_q;
	role_t       role_q;
	logic        act_q, ra_q, started_q;
	logic [15:0] leader_q, cnt_q;
	logic [23:0] rt_q, ct_q, at_q;

	logic [15:0] id, nxt;
	role_t       n_role;
	logic        n_act, n_ra, n_started;
	logic [15:0] n_leader, n_cnt;
	logic [23:0] n_rt, n_ct, n_at;
	msg_t [2:0]  msgs;
	logic [1:0]  n;
	logic        accept;

	assign item.ready = !q_full;
	assign accept     = item.valid && !q_full;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q  <= 16'd1;
			elec_to_q  <= 24'd1024;
			coord_to_q <= 24'd1920;
			alive_to_q <= 24'd1280;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_NODE_ID:        node_id_q  <= wr_data[15:0];
				REG_ELECTION_TO:    elec_to_q  <= wr_data;
				REG_COORDINATOR_TO: coord_to_q <= wr_data;
				REG_ALIVE_INTERVAL: alive_to_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Next state and messages for the item at the port
	always_comb begin
		id        = (node_id_q == 16'd0) ? 16'd1 : node_id_q;
		nxt       = (id >= RING_NODES) ? 16'd1 : id + 16'd1;
		n_role    = role_q;
		n_act     = act_q;
		n_ra      = ra_q;
		n_started = started_q;
		n_leader  = leader_q;
		n_cnt     = cnt_q;
		n_rt      = rt_q;
		n_ct      = ct_q;
		n_at      = at_q;
		msgs      = '0;
		n         = 2'd0;
		case (mode_t'(item.mode))
			MODE_TICK: begin
				if (started_q) begin
					// retry timer
					if (ra_q) begin
						if (rt_q <= 24'd1) begin
							if (n_role == ROLE_ELECTION && n_act) begin
								n_role  = ROLE_ELECTION;
								n_cnt   = n_cnt + 16'd1;
								n_act   = 1'b1;
								msgs[n] = '{KIND_ELECTION, id, id, n_cnt};
								n       = n + 2'd1;
								n_rt    = load_val(elec_to_q);
							end else begin
								n_ra = 1'b0;
								n_rt = 24'd0;
							end
						end else begin
							n_rt = rt_q - 24'd1;
						end
					end
					// missing-leader check
					if (ct_q <= 24'd1) begin
						if (n_leader == 16'd0 && !n_act) begin
							n_role  = ROLE_ELECTION;
							n_cnt   = n_cnt + 16'd1;
							n_act   = 1'b1;
							msgs[n] = '{KIND_ELECTION, id, id, n_cnt};
							n       = n + 2'd1;
							n_rt    = load_val(elec_to_q);
							n_ra    = 1'b1;
						end
						n_ct = load_val(coord_to_q);
					end else begin
						n_ct = ct_q - 24'd1;
					end
					// heartbeat
					if (at_q <= 24'd1) begin
						if (n_leader == id) begin
							msgs[n] = '{KIND_ALIVE, id, id, n_cnt};
							n       = n + 2'd1;
						end
						n_at = load_val(alive_to_q);
					end else begin
						n_at = at_q - 24'd1;
					end
				end
			end
			MODE_MSG: begin
				if (item.frame_size_ok && item.msg_target == id) begin
					if (item.msg_kind == {6'd0, KIND_ELECTION}) begin
						if (item.msg_initiator == id) begin
							n_leader = item.msg_candidate;
							n_role   = ROLE_NORMAL;
							n_act    = 1'b0;
							msgs[0]  = '{KIND_COORD, id, item.msg_candidate, item.msg_sequence};
						end else begin
							n_role  = ROLE_ELECTION;
							n_act   = 1'b1;
							msgs[0] = '{KIND_ELECTION, item.msg_initiator,
								(id > item.msg_candidate) ? id : item.msg_candidate,
								item.msg_sequence};
						end
						n = 2'd1;
					end else if (item.msg_kind == {6'd0, KIND_COORD}) begin
						if (!(item.msg_initiator == id && leader_q == id)) begin
							n_leader = item.msg_candidate;
							n_role   = ROLE_NORMAL;
							n_act    = 1'b0;
							msgs[0]  = '{KIND_COORD, item.msg_initiator, item.msg_candidate,
								item.msg_sequence};
							n        = 2'd1;
						end
					end else if (item.msg_kind == {6'd0, KIND_ALIVE}) begin
						if (!(item.msg_initiator == id && leader_q == id) &&
							item.msg_initiator == leader_q) begin
							msgs[0] = '{KIND_ALIVE, item.msg_initiator, item.msg_candidate,
								item.msg_sequence};
							n       = 2'd1;
						end
					end
				end
			end
			MODE_START: begin
				if (!started_q) begin
					n_started = 1'b1;
					if (id == RING_NODES) begin
						if (!n_act) begin
							n_role  = ROLE_ELECTION;
							n_cnt   = n_cnt + 16'd1;
							n_act   = 1'b1;
							msgs[0] = '{KIND_ELECTION, id, id, n_cnt};
							n       = 2'd1;
						end
						n_rt = load_val(elec_to_q);
						n_ra = 1'b1;
					end
					n_ct = load_val(coord_to_q);
					n_at = load_val(alive_to_q);
				end
			end
			default: ;
		endcase
	end

	// Bundle toward the queue
	always_comb begin
		qpush.push          = accept;
		qpush.data.nres     = (n == 2'd0) ? 2'd1 : n;
		qpush.data.has_msg  = (n != 2'd0);
		qpush.data.msgs     = msgs;
		qpush.data.target   = nxt;
		qpush.data.leader   = n_leader;
		qpush.data.role     = n_role;
		qpush.data.electing = n_act;
	end

	// Node state update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q    <= ROLE_NORMAL;
			act_q     <= 1'b0;
			leader_q  <= 16'd0;
			cnt_q     <= 16'd0;
			rt_q      <= 24'd0;
			ra_q      <= 1'b0;
			ct_q      <= 24'd0;
			at_q      <= 24'd0;
			started_q <= 1'b0;
		end else if (accept) begin
			role_q    <= n_role;
			act_q     <= n_act;
			leader_q  <= n_leader;
			cnt_q     <= n_cnt;
			rt_q      <= n_rt;
			ra_q      <= n_ra;
			ct_q      <= n_ct;
			at_q      <= n_at;
			started_q <= n_started;
		end
	end

endmodule

`default_nettype wire

[src/rle_queue.sv]
// Short bundle queue between front and back.
`default_nettype none

module rle_queue import rle_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire qpush_t qpush,
	output logic        full,
	output qhead_t      head,
	input  wire logic   pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full       = (cnt_q == CW'(DEPTH));
	assign do_push    = qpush.push && !full;
	assign do_pop     = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.data  = mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= qpush.data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/rle_back.sv]
// Back: splits each bundle into result transactions behind an output register.
`default_nettype none

module rle_back import rle_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire qhead_t head,
	output logic        pop,
	rle_out_if.source   result
);

	logic [1:0]  k_q;
	logic        ov_q;
	logic        sv_q, last_q, elect_q;
	logic [1:0]  kind_q, role_q;
	logic [15:0] ini_q, cand_q, seq_q, tgt_q, leader_q;
	logic        load, last;
	msg_t        sel;

	assign load = head.valid && (!ov_q || result.ready);
	assign last = (k_q == head.data.nres - 2'd1);
	assign pop  = load && last;
	assign sel  = head.data.msgs[k_q];

	// Result index within the head bundle and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= 2'd0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				k_q <= last ? 2'd0 : k_q + 2'd1;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			sv_q     <= head.data.has_msg;
			kind_q   <= sel.kind;
			ini_q    <= sel.initiator;
			cand_q   <= sel.candidate;
			seq_q    <= sel.seqnum;
			tgt_q    <= head.data.has_msg ? head.data.target : 16'd0;
			leader_q <= head.data.leader;
			role_q   <= head.data.role;
			elect_q  <= head.data.electing;
			last_q   <= last;
		end
	end

	assign result.valid         = ov_q;
	assign result.send_valid    = sv_q;
	assign result.out_kind      = kind_q;
	assign result.out_initiator = ini_q;
	assign result.out_candidate = cand_q;
	assign result.out_sequence  = seq_q;
	assign result.out_target    = tgt_q;
	assign result.leader_now    = leader_q;
	assign result.role_now      = role_q;
	assign result.electing_now  = elect_q;
	assign result.last_result   = last_q;

endmodule

`default_nettype wire

[src/ring_leader_election_node_core.sv]
// Top level of the ring leader election node.
//
//   channel   dir   handshake          carries
//   item      in    valid/ready        mode, frame_size_ok, msg_* fields
//   result    out   valid/ready        send_valid, out_* fields, status, last_result
//   config    in    wr_en              wr_index, wr_data (24 bits)
//
// The front accepts one item per cycle while the bundle queue has room and
// computes all state updates for that item in the same cycle.
// The back delivers one result per cycle while the result side is ready; an item
// that sends n messages (at most two, on a tick) yields n result transactions.
// Reset (arst_n low) returns state and registers to defaults at once.
// A stalled result leaves the item side running until the queue fills.
`default_nettype none

module ring_leader_election_node_core import rle_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [23:0] wr_data,
	rle_in_if.sink           item,
	rle_out_if.source        result
);

	qpush_t qpush;
	qhead_t qhead;
	logic   q_full;
	logic   q_pop;

	rle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item),
		.q_full   (q_full),
		.qpush    (qpush)
	);

	rle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.full   (q_full),
		.head   (qhead),
		.pop    (q_pop)
	);

	rle_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (qhead),
		.pop    (q_pop),
		.result (result)
	);

	// Front never pushes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qpush.push |-> !q_full)
		else $error("push into full queue");

	// A bundle's results come without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.last_result |=> result.valid)
		else $error("gap inside a bundle");

	// A result without a message is the only result of its item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.send_valid |-> result.last_result)
		else $error("empty result not last");

	// Sent messages always name a ring neighbor, empty results none
	a_target: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.send_valid == (result.out_target != 16'd0)))
		else $error("target inconsistent with send_valid");

endmodule

`default_nettype wire

[bench/ring_leader_election_node_core_tb.sv]
// Self-checking testbench for the ring leader election node core.
`default_nettype none

module ring_leader_election_node_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rle_pkg::*;

	// Received message kinds as they appear on the 8-bit msg_kind field
	localparam logic [7:0] MK_NONE     = 8'(KIND_NONE);
	localparam logic [7:0] MK_ELECTION = 8'(KIND_ELECTION);
	localparam logic [7:0] MK_COORD    = 8'(KIND_COORD);
	localparam logic [7:0] MK_ALIVE    = 8'(KIND_ALIVE);
	localparam logic [7:0] MK_BOGUS    = 8'hFF;

	localparam int IDLE_LIMIT = 2000;
	localparam int N_DIR      = 22;
	localparam int PHASE_B    = 14;

	// One input transaction; typed rows carry their expected status inline
	typedef struct packed {
		logic        typed;
		logic [15:0] x_leader;
		role_t       x_role;
		logic        x_elect;
		mode_t       mode;
		logic        fok;
		logic [7:0]  kind;
		logic [15:0] ini;
		logic [15:0] cand;
		logic [15:0] seq;
		logic [15:0] tgt;
	} stim_t;

	// One outgoing message
	typedef struct packed {
		kind_t       kind;
		logic [15:0] ini;
		logic [15:0] cand;
		logic [15:0] seq;
	} exp_msg_t;

	// One result transaction
	typedef struct packed {
		logic        send;
		kind_t       kind;
		logic [15:0] ini;
		logic [15:0] cand;
		logic [15:0] seq;
		logic [15:0] tgt;
		logic [15:0] leader;
		role_t       role;
		logic        elect;
		logic        last;
	} ring_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	reg_idx_t    wr_index = REG_NODE_ID;
	logic [23:0] wr_data = 24'd0;
	logic        sink_ready = 1'b0;

	rle_in_if  item_ch ();
	rle_out_if res_ch ();

	assign res_ch.ready = sink_ready;

	ring_leader_election_node_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch),
		.result   (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Node state mirror and register copies
	logic [15:0] nd_node = 16'd1;
	logic [23:0] nd_elec_to = 24'd1024;
	logic [23:0] nd_coord_to = 24'd1920;
	logic [23:0] nd_alive_to = 24'd1280;
	role_t       nd_role = ROLE_NORMAL;
	logic        nd_active = 1'b0;
	logic [15:0] nd_leader = 16'd0;
	logic [15:0] nd_count = 16'd0;
	logic [23:0] nd_retry_t = 24'd0;
	logic        nd_retry_armed = 1'b0;
	logic [23:0] nd_coord_t = 24'd0;
	logic [23:0] nd_alive_t = 24'd0;
	logic        nd_started = 1'b0;

	exp_msg_t  outbox[$];
	ring_res_t step_results[$];
	ring_res_t pending_results[$];
	stim_t     stim_log[$];

	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int stall_window = 0;

	// Directed stimulus: node 1 with default registers, then node 6 with 1-tick timers
	stim_t dir_tab [N_DIR] = '{
		// tick before start, ignored mode, bad frame, wrong target, unknown kinds
		'{1'b1, 16'd0, ROLE_NORMAL, 1'b0, MODE_TICK, 1'b0, MK_NONE,
			16'd0, 16'd0, 16'd0, 16'd0},
		'{1'b1, 16'd0, ROLE_NORMAL, 1'b0, MODE_NONE, 1'b1, MK_BOGUS,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		'{1'b1, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b0, MK_ELECTION,
			16'd3, 16'd5, 16'd7, 16'd1},
		'{1'b1, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_ELECTION,
			16'd3, 16'd5, 16'd7, 16'd2},
		'{1'b1, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_BOGUS,
			16'd3, 16'd5, 16'd7, 16'd1},
		'{1'b1, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_NONE,
			16'd3, 16'd5, 16'd7, 16'd1},
		// election forwarding: larger candidate, then own id wins
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_ELECTION,
			16'd3, 16'd5, 16'd7, 16'd1},
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_ELECTION,
			16'd3, 16'd0, 16'd0, 16'd1},
		// own election returns: becomes coordinator announcement
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_ELECTION,
			16'd1, 16'hFFFF, 16'hFFFF, 16'd1},
		// alive from leader forwarded, from a stranger dropped
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_ALIVE,
			16'hFFFF, 16'd0, 16'd0, 16'd1},
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_ALIVE,
			16'd4, 16'd4, 16'd1, 16'd1},
		// coordinator makes this node leader, then returns and alive returns
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_COORD,
			16'd7, 16'd1, 16'd3, 16'd1},
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_COORD,
			16'd1, 16'd1, 16'd3, 16'd1},
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_ALIVE,
			16'd1, 16'd1, 16'd3, 16'd1},
		// highest node starts an election; second start ignored
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_START, 1'b0, MK_NONE,
			16'd0, 16'd0, 16'd0, 16'd0},
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_START, 1'b1, MK_BOGUS,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		// retry timer restarts the unfinished election
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_TICK, 1'b0, MK_NONE,
			16'd0, 16'd0, 16'd0, 16'd0},
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_COORD,
			16'd6, 16'd6, 16'd2, 16'd6},
		// leader heartbeat on tick
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_TICK, 1'b1, MK_BOGUS,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_ELECTION,
			16'd2, 16'd3, 16'd5, 16'd6},
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_TICK, 1'b0, MK_NONE,
			16'd0, 16'd0, 16'd0, 16'd0},
		'{1'b0, 16'd0, ROLE_NORMAL, 1'b0, MODE_MSG, 1'b1, MK_ALIVE,
			16'd6, 16'd6, 16'd0, 16'd6}
	};

	function automatic logic [15:0] self_id();
		return (nd_node == 16'd0) ? 16'd1 : nd_node;
	endfunction

	function automatic logic [15:0] ring_next();
		return (self_id() >= RING_NODES) ? 16'd1 : self_id() + 16'd1;
	endfunction

	function automatic logic [23:0] reload(input logic [23:0] r);
		return (r == 24'd0) ? 24'd1 : r;
	endfunction

	task automatic post(input kind_t k, input logic [15:0] ini, cand, seq);
		if (outbox.size() < 3)
			outbox.push_back('{k, ini, cand, seq});
	endtask

	task automatic open_election();
		if (!nd_active) begin
			nd_role   = ROLE_ELECTION;
			nd_count  = nd_count + 16'd1;
			nd_active = 1'b1;
			post(KIND_ELECTION, self_id(), self_id(), nd_count);
		end
	endtask

	// Advance the node mirror by one transaction; results land in step_results
	task automatic election_predict(input stim_t s);
		logic [15:0] id;
		ring_res_t   r;
		int          n;
		id = self_id();
		outbox.delete();
		step_results.delete();
		case (s.mode)
			MODE_TICK: begin
				if (nd_started) begin
					// retry, then missing-leader check, then heartbeat
					if (nd_retry_armed) begin
						if (nd_retry_t <= 24'd1) begin
							if (nd_role == ROLE_ELECTION && nd_active) begin
								nd_active = 1'b0;
								open_election();
								nd_retry_t = reload(nd_elec_to);
							end else begin
								nd_retry_armed = 1'b0;
								nd_retry_t = 24'd0;
							end
						end else
							nd_retry_t = nd_retry_t - 24'd1;
					end
					if (nd_coord_t <= 24'd1) begin
						if (nd_leader == 16'd0 && !nd_active) begin
							open_election();
							nd_retry_t = reload(nd_elec_to);
							nd_retry_armed = 1'b1;
						end
						nd_coord_t = reload(nd_coord_to);
					end else
						nd_coord_t = nd_coord_t - 24'd1;
					if (nd_alive_t <= 24'd1) begin
						if (nd_leader == id)
							post(KIND_ALIVE, id, id, nd_count);
						nd_alive_t = reload(nd_alive_to);
					end else
						nd_alive_t = nd_alive_t - 24'd1;
				end
			end
			MODE_MSG: begin
				if (s.fok && s.tgt == id) begin
					if (s.kind == MK_ELECTION) begin
						if (s.ini == id) begin
							nd_leader = s.cand;
							nd_role   = ROLE_NORMAL;
							nd_active = 1'b0;
							post(KIND_COORD, id, s.cand, s.seq);
						end else begin
							nd_role   = ROLE_ELECTION;
							nd_active = 1'b1;
							post(KIND_ELECTION, s.ini, (id > s.cand) ? id : s.cand, s.seq);
						end
					end else if (s.kind == MK_COORD) begin
						if (!(s.ini == id && nd_leader == id)) begin
							nd_leader = s.cand;
							nd_role   = ROLE_NORMAL;
							nd_active = 1'b0;
							post(KIND_COORD, s.ini, s.cand, s.seq);
						end
					end else if (s.kind == MK_ALIVE) begin
						if (!(s.ini == id && nd_leader == id) && s.ini == nd_leader)
							post(KIND_ALIVE, s.ini, s.cand, s.seq);
					end
				end
			end
			MODE_START: begin
				if (!nd_started) begin
					nd_started = 1'b1;
					if (id == RING_NODES) begin
						open_election();
						nd_retry_t = reload(nd_elec_to);
						nd_retry_armed = 1'b1;
					end
					nd_coord_t = reload(nd_coord_to);
					nd_alive_t = reload(nd_alive_to);
				end
			end
			default: ;
		endcase
		n = (outbox.size() == 0) ? 1 : outbox.size();
		for (int k = 0; k < n; k++) begin
			r = '0;
			if (k < outbox.size()) begin
				r.send = 1'b1;
				r.kind = outbox[k].kind;
				r.ini  = outbox[k].ini;
				r.cand = outbox[k].cand;
				r.seq  = outbox[k].seq;
				r.tgt  = ring_next();
			end
			r.leader = nd_leader;
			r.role   = nd_role;
			r.elect  = nd_active;
			r.last   = (k == n - 1);
			step_results.push_back(r);
		end
	endtask

	function automatic void chk_field(input string name, input logic [15:0] want, got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Random transaction: mostly well-formed messages and ticks, some noise
	function automatic stim_t random_item();
		stim_t       s;
		int          pick;
		logic [15:0] id;
		s = '0;
		id = self_id();
		pick = $urandom_range(99);
		s.fok  = 1'($urandom);
		s.kind = 8'($urandom);
		s.ini  = 16'($urandom);
		s.cand = 16'($urandom);
		s.seq  = 16'($urandom);
		s.tgt  = 16'($urandom);
		if (pick < 35)
			s.mode = MODE_TICK;
		else if (pick < 85) begin
			s.mode = MODE_MSG;
			s.fok  = 1'b1;
			s.tgt  = id;
			case ($urandom_range(2))
				0: s.kind = MK_ELECTION;
				1: s.kind = MK_COORD;
				default: s.kind = MK_ALIVE;
			endcase
			case ($urandom_range(3))
				0: s.ini = id;
				1: s.ini = nd_leader;
				2: s.ini = 16'($urandom_range(1, RING_NODES));
				default: ;
			endcase
			case ($urandom_range(3))
				0: s.cand = id;
				1: s.cand = 16'($urandom_range(8));
				2: s.cand = 16'hFFFF;
				default: ;
			endcase
		end else if (pick < 93)
			s.mode = MODE_MSG;
		else if (pick < 97)
			s.mode = MODE_START;
		else
			s.mode = MODE_NONE;
		return s;
	endfunction

	// Offer one transaction, with bursts and random gaps between them
	task automatic push_item(input stim_t s);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(3) != 0) begin
				item_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		stim_log.push_back(s);
		item_ch.valid         <= 1'b1;
		item_ch.mode          <= s.mode;
		item_ch.frame_size_ok <= s.fok;
		item_ch.msg_kind      <= s.kind;
		item_ch.msg_initiator <= s.ini;
		item_ch.msg_candidate <= s.cand;
		item_ch.msg_sequence  <= s.seq;
		item_ch.msg_target    <= s.tgt;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [23:0] v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(posedge clk);
		case (idx)
			REG_NODE_ID:        nd_node = v[15:0];
			REG_ELECTION_TO:    nd_elec_to = v;
			REG_COORDINATOR_TO: nd_coord_to = v;
			REG_ALIVE_INTERVAL: nd_alive_to = v;
			default: ;
		endcase
	endtask

	// Drain the block, then load all four registers
	task automatic set_regs(input logic [15:0] node, input logic [23:0] e, c, a);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		reg_write(REG_NODE_ID, {8'd0, node});
		reg_write(REG_ELECTION_TO, e);
		reg_write(REG_COORDINATOR_TO, c);
		reg_write(REG_ALIVE_INTERVAL, a);
		wr_en <= 1'b0;
		burst_left = 0;
	endtask

	// Result sink: random ready, with a stall level redrawn at the start of each window
	always @(posedge clk) begin
		if (stall_window == 0) begin
			stall_window <= 48;
			case ($urandom_range(4))
				0, 1: stall_pct <= 0;
				2: stall_pct <= 30;
				3: stall_pct <= 60;
				default: stall_pct <= 85;
			endcase
		end else
			stall_window <= stall_window - 1;
		sink_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Prediction on accepted inputs, checking on accepted results, watchdog
	always @(posedge clk) begin : monitor
		stim_t     s;
		ring_res_t want;
		ring_res_t quiet;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				s = stim_log.pop_front();
				election_predict(s);
				if (s.typed) begin
					quiet = '0;
					quiet.leader = s.x_leader;
					quiet.role   = s.x_role;
					quiet.elect  = s.x_elect;
					quiet.last   = 1'b1;
					pending_results.push_back(quiet);
				end else
					foreach (step_results[k]) pending_results.push_back(step_results[k]);
			end
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transaction");
					errors++;
				end else begin
					want = pending_results.pop_front();
					chk_field("send_valid", 16'(want.send), 16'(res_ch.send_valid));
					chk_field("out_kind", 16'(want.kind), 16'(res_ch.out_kind));
					chk_field("out_initiator", want.ini, res_ch.out_initiator);
					chk_field("out_candidate", want.cand, res_ch.out_candidate);
					chk_field("out_sequence", want.seq, res_ch.out_sequence);
					chk_field("out_target", want.tgt, res_ch.out_target);
					chk_field("leader_now", want.leader, res_ch.leader_now);
					chk_field("role_now", 16'(want.role), 16'(res_ch.role_now));
					chk_field("electing_now", 16'(want.elect), 16'(res_ch.electing_now));
					chk_field("last_result", 16'(want.last), 16'(res_ch.last_result));
				end
			end
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		item_ch.valid         = 1'b0;
		item_ch.mode          = MODE_TICK;
		item_ch.frame_size_ok = 1'b0;
		item_ch.msg_kind      = 8'd0;
		item_ch.msg_initiator = 16'd0;
		item_ch.msg_candidate = 16'd0;
		item_ch.msg_sequence  = 16'd0;
		item_ch.msg_target    = 16'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		for (int i = 0; i < N_DIR; i++) begin
			if (i == PHASE_B)
				set_regs(16'd6, 24'd1, 24'd1, 24'd1);
			push_item(dir_tab[i]);
		end

		// Random part over several register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_regs(16'd6, 24'($urandom_range(1, 4)), 24'($urandom_range(2, 6)),
					24'($urandom_range(2, 6)));
				1: set_regs(16'hFFFF, 24'd0, 24'd0, 24'd0);
				2: set_regs(16'd0, 24'd3, 24'd5, 24'd4);
				3: set_regs(16'($urandom_range(1, 6)), 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
				default: set_regs(16'($urandom_range(1, 5)), 24'($urandom_range(1, 8)), 24'd1,
					24'($urandom_range(1, 3)));
			endcase
			repeat (20) push_item(random_item());
		end

		// Drain and report
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
